/* hdl/affine_2d_point_transform_macros.svh */
// Assertion macros for the 2D affine point transform.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef AFFINE_2D_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_2D_POINT_TRANSFORM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define A2DPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define A2DPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/a2dpt_pkg.sv */
// Shared types and constants for the 2D affine point transform.
// No dependencies; imported by a2dpt_sincos and the top level.
`default_nettype none

package a2dpt_pkg;

  localparam int TRIG_FRAC = 30;
  localparam int TRIG_W    = 34;
  localparam int ANGLE_W   = 43;
  localparam int FIELD_W   = 24;
  localparam int OUT_W     = 16;

  localparam logic [41:0] PI_Q40          = 42'h3243F6A8886;
  localparam logic signed [TRIG_W-1:0] CORDIC_K_Q30 = 34'sh026DD3B6A;

  localparam logic [17:0] ANGLE_OFFSET = 18'd72000;
  localparam logic [17:0] ANGLE_FULL   = 18'd36000;
  localparam logic [15:0] ANGLE_HALF   = 16'd18000;
  localparam logic [15:0] ANGLE_QUART  = 16'd9000;

  // pi split as PI_QUO * 18000 + PI_REM, so r*pi/18000 = r*PI_QUO + r*PI_REM/18000;
  // the remainder part is divided by 16 then by 1125 through a reciprocal,
  // exact for dividends below 2^24
  localparam logic [27:0] PI_QUO     = 28'(PI_Q40 / 42'd18000);
  localparam logic [14:0] PI_REM     = 15'(PI_Q40 % 42'd18000);
  localparam int          RECIP_SH   = 35;
  localparam logic [24:0] RECIP_1125 = 25'(((64'd1 << 35) + 64'd1124) / 64'd1125);

  // transform modes
  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_ROTATE    = 3'd1;
  localparam logic [2:0] MODE_SCALE     = 3'd2;
  localparam logic [2:0] MODE_SHEAR     = 3'd3;
  localparam logic [2:0] MODE_REFLECT   = 3'd4;

  // reflection axes
  localparam logic [1:0] AXIS_ORIGIN = 2'd0;
  localparam logic [1:0] AXIS_X      = 2'd1;
  localparam logic [1:0] AXIS_Y      = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_PX    = 3'd1;
  localparam logic [2:0] REG_PY    = 3'd2;
  localparam logic [2:0] REG_ANGLE = 3'd3;
  localparam logic [2:0] REG_AXIS  = 3'd4;

  // final shift selection
  localparam logic [1:0] SH_F   = 2'd0;
  localparam logic [1:0] SH_2F  = 2'd1;
  localparam logic [1:0] SH_ROT = 2'd2;

  typedef struct packed {
    logic                     busy;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } a2dpt_trig_t;

  function automatic longint odd_div(input longint v, input int n);
    unique case (n)
      0:  return v;
      1:  return v / 3;
      2:  return v / 5;
      3:  return v / 7;
      4:  return v / 9;
      5:  return v / 11;
      6:  return v / 13;
      7:  return v / 15;
      8:  return v / 17;
      9:  return v / 19;
      10: return v / 21;
      11: return v / 23;
      12: return v / 25;
      13: return v / 27;
      14: return v / 29;
      15: return v / 31;
      16: return v / 33;
      17: return v / 35;
      18: return v / 37;
      19: return v / 39;
      default: return v;
    endcase
  endfunction

  // atan(2^-i) in Q40 by truncated series; evaluated at elaboration
  function automatic logic signed [ANGLE_W-1:0] atan_q40(input int i);
    longint sum;
    longint term;
    int     e;
    sum = 0;
    if (i == 0) begin
      sum = longint'(PI_Q40 >> 2);
    end else begin
      for (int n = 0; n < 20; n++) begin
        e = i * (2 * n + 1);
        if (e <= 40) begin
          term = odd_div(longint'(1) << (40 - e), n);
          sum  = n[0] ? sum - term : sum + term;
        end
      end
    end
    return ANGLE_W'(sum);
  endfunction

endpackage

`default_nettype wire

/* hdl/a2dpt_sincos.sv */
// Sine/cosine sequencer: angle reduction, multiply by pi, divide by 18000
// through a constant split and a reciprocal, then an iterative CORDIC. Uses a2dpt_pkg.
`default_nettype none

module a2dpt_sincos import a2dpt_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [16:0] angle_i,
  output a2dpt_trig_t             trig_o
);

  localparam int SW = $clog2(CORDIC_STAGES);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_ROT  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_IDLE = 3'd7;

  logic signed [ANGLE_W-1:0] atan_w [CORDIC_STAGES];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_atan
    assign atan_w[g] = atan_q40(g);
  end

  logic [2:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [17:0] r_q, r_d;
  logic        neg_q, neg_d, flip_q, flip_d;
  logic [13:0] mag_q, mag_d;
  logic [41:0] hi_q, hi_d;
  logic [28:0] lo_q, lo_d;
  logic signed [TRIG_W-1:0]  x_q, x_d, y_q, y_d, cos_q, cos_d, sin_q, sin_d;
  logic signed [ANGLE_W-1:0] z_q, z_d;

  logic signed [17:0] rs_a, rs_b;
  logic        flip_c;
  logic [49:0] rec_w;
  logic [41:0] quo_w;
  logic signed [TRIG_W-1:0] xs, ys;
  logic signed [ANGLE_W-1:0] q_s;

  always_comb begin
    // fold into -9000..9000
    rs_a   = (r_q > 18'(ANGLE_HALF)) ? $signed(r_q) - $signed(ANGLE_FULL) : $signed(r_q);
    flip_c = 1'b0;
    rs_b   = rs_a;
    if (rs_a > $signed({2'b00, ANGLE_QUART})) begin
      rs_b   = rs_a - $signed({2'b00, ANGLE_HALF});
      flip_c = 1'b1;
    end else if (rs_a < -$signed({2'b00, ANGLE_QUART})) begin
      rs_b   = rs_a + $signed({2'b00, ANGLE_HALF});
      flip_c = 1'b1;
    end
    // floor(lo / 18000) = floor(floor(lo / 16) / 1125)
    rec_w = 50'(lo_q[28:4]) * 50'(RECIP_1125);
    quo_w = hi_q + 42'(rec_w[49:RECIP_SH]);
    q_s   = $signed(ANGLE_W'(quo_w));
    xs    = x_q >>> cnt_q[SW-1:0];
    ys    = y_q >>> cnt_q[SW-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    neg_d   = neg_q;
    flip_d  = flip_q;
    mag_d   = mag_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    unique case (state_q)
      ST_LOAD: begin
        r_d     = 18'($signed({{2{angle_i[16]}}, angle_i}) + $signed({1'b0, ANGLE_OFFSET}));
        state_d = ST_RED;
      end
      ST_RED: begin
        if (r_q >= ANGLE_FULL) begin
          r_d = r_q - ANGLE_FULL;
        end else begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        neg_d   = rs_b[17];
        flip_d  = flip_c;
        mag_d   = rs_b[17] ? 14'(-rs_b) : 14'(rs_b);
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        hi_d    = 42'(mag_q) * 42'(PI_QUO);
        lo_d    = 29'(mag_q) * 29'(PI_REM);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        z_d     = neg_q ? -q_s : q_s;
        x_d     = CORDIC_K_Q30;
        y_d     = '0;
        cnt_d   = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        if (z_q[ANGLE_W-1]) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_w[cnt_q[SW-1:0]];
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_w[cnt_q[SW-1:0]];
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(CORDIC_STAGES - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cos_d   = flip_q ? -x_q : x_q;
        sin_d   = flip_q ? -y_q : y_q;
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
      end
      default: state_d = ST_IDLE;
    endcase
    if (start_i) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    neg_q  <= neg_d;
    flip_q <= flip_d;
    mag_q  <= mag_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  assign trig_o.busy  = state_q != ST_IDLE;
  assign trig_o.cos_v = cos_q;
  assign trig_o.sin_v = sin_q;

endmodule

`default_nettype wire

/* hdl/affine_2d_point_transform.sv */
// Throughput one word per cycle when not stalled. The pipeline (operand select,
// multiply, sum, truncate/saturate) stalls as a whole on m_axis_tready. After reset
// and after each angle write, the sin/cos sequencer runs (angle reduction, fold,
// multiply, divide, CORDIC rotation, finish) with s_axis_tready low.
// rst_ni clears config registers and valid bits asynchronously.
// Depends on a2dpt_pkg, a2dpt_sincos and the assertion macro header.
`default_nettype none
`include "affine_2d_point_transform_macros.svh"

module affine_2d_point_transform import a2dpt_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // vertex_x [23:0], vertex_y [47:24]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // out_x [15:0], out_y [31:16]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = FIELD_W + 1;
  localparam int PW = AW + TRIG_W;
  localparam int CW = FIELD_W + TRIG_FRAC + 2;
  localparam int SUMW = PW + 3;

  // ---------------- configuration ----------------
  logic [2:0]         mode_q;
  logic signed [23:0] px_q, py_q;
  logic signed [16:0] angle_q;
  logic [1:0]         axis_q;
  logic               wr;
  logic [2:0]         widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      px_q    <= '0;
      py_q    <= '0;
      angle_q <= '0;
      axis_q  <= '0;
    end else if (wr) begin
      unique case (widx)
        REG_MODE:  mode_q  <= pwdata[2:0];
        REG_PX:    px_q    <= pwdata[23:0];
        REG_PY:    py_q    <= pwdata[23:0];
        REG_ANGLE: angle_q <= pwdata[16:0];
        REG_AXIS:  axis_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MODE:  prdata = {29'd0, mode_q};
      REG_PX:    prdata = {8'd0, px_q};
      REG_PY:    prdata = {8'd0, py_q};
      REG_ANGLE: prdata = {15'd0, angle_q};
      REG_AXIS:  prdata = {30'd0, axis_q};
      default:   prdata = '0;
    endcase
  end

  a2dpt_trig_t trig;

  a2dpt_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wr && widx == REG_ANGLE),
    .angle_i (angle_q),
    .trig_o  (trig)
  );

  // ---------------- pipeline ----------------
  logic en, acc;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en            = !v4_q || m_axis_tready;
  assign s_axis_tready = en && !trig.busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  logic signed [FIELD_W-1:0] vx, vy;
  logic signed [AW-1:0]      ex, ey, dx, dy;
  logic signed [TRIG_W-1:0]  one, fone, epx, epy;
  logic signed [CW-1:0]      cpx, cpy;

  logic signed [AW-1:0]     a1x_d, a2x_d, a1y_d, a2y_d;
  logic signed [TRIG_W-1:0] b1x_d, b2x_d, b1y_d, b2y_d;
  logic signed [CW-1:0]     cx_d, cy_d;
  logic [1:0]               sh_d;

  logic signed [AW-1:0]     a1x_q, a2x_q, a1y_q, a2y_q;
  logic signed [TRIG_W-1:0] b1x_q, b2x_q, b1y_q, b2y_q;
  logic signed [CW-1:0]     cx_q, cy_q, cx2_q, cy2_q;
  logic [1:0]               sh1_q, sh2_q, sh3_q;
  logic signed [PW-1:0]     p1x_q, p2x_q, p1y_q, p2y_q;
  logic signed [SUMW-1:0]   sx_q, sy_q;
  logic [OUT_W-1:0]         ox_q, oy_q;

  always_comb begin
    vx   = s_axis_tdata[23:0];
    vy   = s_axis_tdata[47:24];
    ex   = AW'(vx);
    ey   = AW'(vy);
    dx   = ex - AW'(px_q);
    dy   = ey - AW'(py_q);
    one  = TRIG_W'(1);
    fone = TRIG_W'(1) <<< FRAC_BITS;
    epx  = TRIG_W'(px_q);
    epy  = TRIG_W'(py_q);
    cpx  = CW'(px_q) <<< TRIG_FRAC;
    cpy  = CW'(py_q) <<< TRIG_FRAC;

    a1x_d = ex; b1x_d = one; a2x_d = '0; b2x_d = '0; cx_d = '0;
    a1y_d = ey; b1y_d = one; a2y_d = '0; b2y_d = '0; cy_d = '0;
    sh_d  = SH_F;
    unique case (mode_q)
      MODE_TRANSLATE: begin
        a2x_d = AW'(px_q); b2x_d = one;
        a2y_d = AW'(py_q); b2y_d = one;
      end
      MODE_ROTATE: begin
        a1x_d = dx; b1x_d = trig.cos_v; a2x_d = dy; b2x_d = -trig.sin_v; cx_d = cpx;
        a1y_d = dx; b1y_d = trig.sin_v; a2y_d = dy; b2y_d = trig.cos_v;  cy_d = cpy;
        sh_d  = SH_ROT;
      end
      MODE_SCALE: begin
        b1x_d = epx;
        b1y_d = epy;
        sh_d  = SH_2F;
      end
      MODE_SHEAR: begin
        b1x_d = fone; a2x_d = ey; b2x_d = epx;
        a1y_d = ex;   b1y_d = epy; a2y_d = ey; b2y_d = fone;
        sh_d  = SH_2F;
      end
      MODE_REFLECT: begin
        unique case (axis_q)
          AXIS_ORIGIN: begin b1x_d = -one; b1y_d = -one; end
          AXIS_X:      begin b1x_d = one;  b1y_d = -one; end
          AXIS_Y:      begin b1x_d = -one; b1y_d = one;  end
          default:     begin b1x_d = '0;   b1y_d = '0;   end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // truncate toward zero at the chosen point, then saturate
  function automatic logic [OUT_W-1:0] finish(input logic signed [SUMW-1:0] v,
                                              input logic [1:0] sh);
    logic [SUMW-1:0] mag;
    logic [SUMW-1:0] shd;
    mag = v[SUMW-1] ? SUMW'(-v) : SUMW'(v);
    unique case (sh)
      SH_2F:   shd = mag >> (2 * FRAC_BITS);
      SH_ROT:  shd = mag >> (FRAC_BITS + TRIG_FRAC);
      default: shd = mag >> FRAC_BITS;
    endcase
    if (v[SUMW-1]) begin
      finish = (shd > SUMW'(32768)) ? 16'h8000 : 16'(-shd);
    end else begin
      finish = (shd > SUMW'(32767)) ? 16'h7FFF : shd[OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1x_q <= a1x_d; b1x_q <= b1x_d; a2x_q <= a2x_d; b2x_q <= b2x_d; cx_q <= cx_d;
      a1y_q <= a1y_d; b1y_q <= b1y_d; a2y_q <= a2y_d; b2y_q <= b2y_d; cy_q <= cy_d;
      sh1_q <= sh_d;
      p1x_q <= a1x_q * b1x_q;
      p2x_q <= a2x_q * b2x_q;
      p1y_q <= a1y_q * b1y_q;
      p2y_q <= a2y_q * b2y_q;
      cx2_q <= cx_q;
      cy2_q <= cy_q;
      sh2_q <= sh1_q;
      sx_q  <= SUMW'(p1x_q) + SUMW'(p2x_q) + SUMW'(cx2_q);
      sy_q  <= SUMW'(p1y_q) + SUMW'(p2y_q) + SUMW'(cy2_q);
      sh3_q <= sh2_q;
      ox_q  <= finish(sx_q, sh3_q);
      oy_q  <= finish(sy_q, sh3_q);
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {oy_q, ox_q};

  // ---------------- assertions ----------------
  `A2DPT_ASSERT_NOW(a_busy_blocks, trig.busy, !s_axis_tready, "input taken while sin/cos busy")
  `A2DPT_ASSERT_NEXT(a_acc_enters, acc, v1_q, "accepted word missing from first stage")
  `A2DPT_ASSERT_NEXT(a_stall_holds, !en && v2_q, v2_q && $stable(p1x_q), "stalled stage lost")

endmodule

`default_nettype wire
